[rtl/string_literal_escaper_macros.svh]
// assertion helpers for the escaper checker
`ifndef STRING_LITERAL_ESCAPER_MACROS_SVH
`define STRING_LITERAL_ESCAPER_MACROS_SVH

// same-cycle implication, idle during reset
`define SLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sle check failed");

// next-cycle implication, idle during reset
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sle check failed");

`endif

[rtl/sle_pkg.sv]
`default_nettype none
package sle_pkg;

  localparam int unsigned STEP_W = 5;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KIND_OPEN,
    KIND_CLOSE,
    KIND_PASS,
    KIND_SHORT,
    KIND_HEX
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } sle_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sle_q_stat_t;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_X = 8'h78;

  localparam logic [7:0] SEQ_OPEN [5] = '{8'h1B, 8'h5B, 8'h33, 8'h35, 8'h6D};
  localparam logic [7:0] SEQ_HI [7] = '{8'h1B, 8'h5B, 8'h31, 8'h3B, 8'h33, 8'h34, 8'h6D};
  localparam logic [7:0] SEQ_LO [7] = '{8'h1B, 8'h5B, 8'h30, 8'h3B, 8'h33, 8'h35, 8'h6D};
  localparam logic [7:0] SEQ_CLOSE [3] = '{8'h1B, 8'h5B, 8'h6D};

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic logic [STEP_W-1:0] run_len(input kind_e kind, input logic colorize);
    logic [STEP_W-1:0] len;
    case (kind)
      KIND_OPEN:  len = colorize ? STEP_W'(6) : STEP_W'(1);
      KIND_CLOSE: len = colorize ? STEP_W'(4) : STEP_W'(1);
      KIND_PASS:  len = STEP_W'(1);
      KIND_SHORT: len = colorize ? STEP_W'(16) : STEP_W'(2);
      KIND_HEX:   len = colorize ? STEP_W'(18) : STEP_W'(4);
      default:    len = STEP_W'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] run_byte(input kind_e kind, input logic [7:0] data,
                                          input logic colorize,
                                          input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] idx;
    logic [STEP_W-1:0] tail;
    logic [7:0]        b;
    idx  = colorize ? (step - STEP_W'(7)) : step;
    tail = STEP_W'(0);
    b    = CHR_QUOTE;
    case (kind)
      KIND_OPEN: begin
        if (colorize && step < STEP_W'(5)) b = SEQ_OPEN[step[2:0]];
        else b = CHR_QUOTE;
      end
      KIND_CLOSE: begin
        tail = step - STEP_W'(1);
        if (step == STEP_W'(0)) b = CHR_QUOTE;
        else b = SEQ_CLOSE[tail[1:0]];
      end
      KIND_PASS: b = data;
      KIND_SHORT: begin
        tail = idx - STEP_W'(2);
        if (colorize && step < STEP_W'(7)) b = SEQ_HI[step[2:0]];
        else if (idx == STEP_W'(0)) b = CHR_BSLASH;
        else if (idx == STEP_W'(1)) b = data;
        else b = SEQ_LO[tail[2:0]];
      end
      KIND_HEX: begin
        tail = idx - STEP_W'(4);
        if (colorize && step < STEP_W'(7)) b = SEQ_HI[step[2:0]];
        else if (idx == STEP_W'(0)) b = CHR_BSLASH;
        else if (idx == STEP_W'(1)) b = CHR_X;
        else if (idx == STEP_W'(2)) b = hex_char(data[7:4]);
        else if (idx == STEP_W'(3)) b = hex_char(data[3:0]);
        else b = SEQ_LO[tail[2:0]];
      end
      default: b = CHR_QUOTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[rtl/sle_in_if.sv]
`default_nettype none
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink (input valid, input mode, input char_byte, output ready);
endinterface
`default_nettype wire

[rtl/sle_out_if.sv]
`default_nettype none
interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/string_literal_escaper.sv]
// Escapes a byte string into a quoted C literal. Send an open word, one data word per
// byte, then a close word; each word yields a run of output bytes, the final one flagged
// by last_of_run. Mode code 3 is swallowed with no output. The back-end sequencer sends
// one output byte per cycle while the output is not stalled; run lengths in bytes are:
// printable bytes 1, open 1 (6 when colorize is set), close 1 (4), a short escape 2 (16),
// a hex escape 4 (18). A small queue between the classifier and the sequencer keeps
// input accepted back to back while plain bytes flow; multi-byte runs or a stalled output
// hold the input off once the queue fills. Write colorize only while the block is idle.
`default_nettype none
module string_literal_escaper
  import sle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  colorize_we_i,
  input  wire logic  colorize_wdata_i,
  sle_in_if.sink     in_i,
  sle_out_if.source  out_o
);

  logic        colorize_q;
  logic        push;
  logic        pop;
  sle_cmd_t    push_cmd;
  sle_cmd_t    head_cmd;
  sle_q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colorize_q <= 1'b0;
    end else if (colorize_we_i) begin
      colorize_q <= colorize_wdata_i;
    end
  end

  sle_front u_front (
    .in_i   (in_i),
    .stat_i (q_stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  sle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  sle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .colorize_i (colorize_q),
    .cmd_i      (head_cmd),
    .stat_i     (q_stat),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

[rtl/sle_fifo.sv]
`default_nettype none
module sle_fifo
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire sle_cmd_t    push_cmd_i,
  input  wire logic        pop_i,
  output sle_cmd_t         head_o,
  output sle_q_stat_t      stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sle_cmd_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  always_comb begin
    stat_o.full  = (count_q == CNT_W'(DEPTH));
    stat_o.empty = (count_q == CNT_W'(0));
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    head_o       = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (do_pop && !do_push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

[rtl/sle_front.sv]
`default_nettype none
module sle_front
  import sle_pkg::*;
(
  sle_in_if.sink          in_i,
  input  wire sle_q_stat_t stat_i,
  output logic            push_o,
  output sle_cmd_t        cmd_o
);

  logic [7:0] esc_chr;

  // letter of the two-character escape, zero when the byte has none
  always_comb begin
    case (in_i.char_byte)
      8'h5C:   esc_chr = 8'h5C;
      8'h22:   esc_chr = 8'h22;
      8'h0A:   esc_chr = 8'h6E;
      8'h09:   esc_chr = 8'h74;
      8'h0D:   esc_chr = 8'h72;
      8'h07:   esc_chr = 8'h61;
      8'h08:   esc_chr = 8'h62;
      8'h0B:   esc_chr = 8'h76;
      default: esc_chr = 8'h00;
    endcase
  end

  always_comb begin
    in_i.ready = !stat_i.full;
    push_o     = 1'b0;
    cmd_o.kind = KIND_PASS;
    cmd_o.data = in_i.char_byte;
    case (in_i.mode)
      MODE_OPEN: begin
        push_o     = in_i.valid;
        cmd_o.kind = KIND_OPEN;
      end
      MODE_CLOSE: begin
        push_o     = in_i.valid;
        cmd_o.kind = KIND_CLOSE;
      end
      MODE_DATA: begin
        push_o = in_i.valid;
        if (esc_chr != 8'h00) begin
          cmd_o.kind = KIND_SHORT;
          cmd_o.data = esc_chr;
        end else if (in_i.char_byte >= 8'h20 && in_i.char_byte <= 8'h7E) begin
          cmd_o.kind = KIND_PASS;
        end else begin
          cmd_o.kind = KIND_HEX;
        end
      end
      // unused mode code: word is taken and dropped
      default: push_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/sle_back.sv]
`default_nettype none
module sle_back
  import sle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        colorize_i,
  input  wire sle_cmd_t    cmd_i,
  input  wire sle_q_stat_t stat_i,
  output logic             pop_o,
  sle_out_if.source        out_o
);

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              advance, load, cur_last;
  logic [STEP_W-1:0] len;
  logic [7:0]        cur_byte;

  always_comb begin
    advance  = !out_valid_q || out_o.ready;
    load     = advance && !stat_i.empty;
    len      = run_len(cmd_i.kind, colorize_i);
    cur_last = (step_q == len - STEP_W'(1));
    cur_byte = run_byte(cmd_i.kind, cmd_i.data, colorize_i, step_q);
    pop_o    = load && cur_last;

    out_valid_d = advance ? !stat_i.empty : out_valid_q;
    step_d      = step_q;
    if (load) step_d = cur_last ? '0 : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;

endmodule
`default_nettype wire

[rtl/sle_checker.sv]
`default_nettype none
`include "string_literal_escaper_macros.svh"
module sle_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  logic out_stall;
  logic esc_taken;

  assign out_stall = out_valid_i && !out_ready_i;
  assign esc_taken = out_valid_i && out_ready_i && (out_byte_i == 8'h1B);

  // a stalled output word holds
  `SLE_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable({out_byte_i, out_last_i}))

  // the last byte of a run is never an escape character
  `SLE_ASSERT_NOW(a_last_not_esc, out_valid_i && out_last_i, out_byte_i != 8'h1B)

  // an escape character is always followed by the bracket
  `SLE_ASSERT_NEXT(a_esc_bracket, esc_taken, out_valid_i && out_byte_i == 8'h5B)

endmodule

bind string_literal_escaper sle_checker u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_of_run)
);
`default_nettype wire
